[rtl/core/vtd_pkg.sv]
// Package for the vertex transform / perspective divide core.
// Holds field widths, register indexes and divider constants. No dependencies.
package vtd_pkg;

    localparam int COORD_W   = 16;   // Q-format coordinate and coefficient width
    localparam int NUM_TERMS = 4;    // x, y, z, w = 1
    localparam int NUM_ROWS  = 4;
    localparam int ROW_W     = NUM_TERMS * COORD_W;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 3;
    localparam int DIV_STEPS = COORD_W + 1;  // quotient magnitude bits incl. one for -32768
    localparam int CFG_IDX_W = 8;
    localparam int TDATA_W   = 48;
    localparam int TUSER_W   = 2;

    localparam logic [DIV_STEPS-1:0] Q_POS_MAX = 17'd32767;
    localparam logic [DIV_STEPS-1:0] Q_NEG_MAX = 17'd32768;
    localparam logic [COORD_W-1:0]   OUT_POS_SAT = 16'h7FFF;
    localparam logic [COORD_W-1:0]   OUT_NEG_SAT = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W = 8'd3;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW_W_RESET = 64'h0100_0000_0000_0000;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

[rtl/core/vertex_transform_divide_core.sv]
// Vertex transform core: 4x4 homogeneous matrix multiply, perspective divide, saturation.
// Depends on vtd_pkg.
//
// Each beat on s_ carries one point (x, y, z) in signed fixed point with FRAC_BITS
// fraction bits; it is extended with w = 1, multiplied by the four matrix rows held in
// registers 0..3, and x, y, z are divided by the w sum, truncated toward zero and clamped
// to 16 bits. A point is accepted every cycle unless stalled. Stages: products, row sums,
// divide setup, 17 restoring-divide steps at one quotient bit per stage, output register.
// The whole pipeline stalls only while the output register holds a beat that is not taken.
// Rows must be written only while no beat is in flight.
module vertex_transform_divide_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [vtd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vtd_pkg::ROW_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vtd_pkg::TDATA_W-1:0]   s_tdata,   // point_x, point_y, point_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vtd_pkg::TDATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
    output logic [vtd_pkg::TUSER_W-1:0]   m_tuser    // div_zero, saturated
);

    localparam int CW    = vtd_pkg::COORD_W;
    localparam int NT    = vtd_pkg::NUM_TERMS;
    localparam int NR    = vtd_pkg::NUM_ROWS;
    localparam int PW    = vtd_pkg::PROD_W;
    localparam int SW    = vtd_pkg::SUM_W;
    localparam int QW    = vtd_pkg::DIV_STEPS;
    localparam int MAG_W = SW + FRAC_BITS;   // |sum * 2^F|
    localparam int DW    = SW;               // |w sum|

    logic m_tvalid_reg;
    logic en;
    assign en       = m_tready || !m_tvalid_reg;
    assign s_tready = en;

    // ---------------- configuration rows ----------------
    logic [vtd_pkg::ROW_W-1:0] row_reg [NR];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= vtd_pkg::ROW_X_RESET;
            row_reg[1] <= vtd_pkg::ROW_Y_RESET;
            row_reg[2] <= vtd_pkg::ROW_Z_RESET;
            row_reg[3] <= vtd_pkg::ROW_W_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vtd_pkg::REG_ROW_X: row_reg[0] <= cfg_wdata;
                vtd_pkg::REG_ROW_Y: row_reg[1] <= cfg_wdata;
                vtd_pkg::REG_ROW_Z: row_reg[2] <= cfg_wdata;
                vtd_pkg::REG_ROW_W: row_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: products ----------------
    vtd_pkg::prod_t prod_reg [NR][NT];
    logic           v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < NR; p++) begin
                for (int t = 0; t < NT - 1; t++) begin
                    prod_reg[p][t] <= $signed(row_reg[p][CW*t +: CW])
                                    * $signed(s_tdata[CW*t +: CW]);
                end
                // w = 1.0 term is a shift of the coefficient
                prod_reg[p][NT-1] <= PW'($signed(row_reg[p][CW*(NT-1) +: CW])) <<< FRAC_BITS;
            end
        end
    end

    // ---------------- stage 2: row sums ----------------
    vtd_pkg::sum_t sum_reg [NR];
    logic          v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < NR; p++) begin
                sum_reg[p] <= SW'(prod_reg[p][0]) + SW'(prod_reg[p][1])
                            + SW'(prod_reg[p][2]) + SW'(prod_reg[p][3]);
            end
        end
    end

    // ---------------- stage 3: divide setup ----------------
    // Pipeline index 0 of the divider holds the setup result.
    logic          dv_reg   [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [DW-1:0] rem_reg  [QW+1][3];
    logic [QW-1:0] nlo_reg  [QW+1][3];
    logic [QW-1:0] quo_reg  [QW+1][3];
    logic          neg_reg  [QW+1][3];
    logic          ovf_reg  [QW+1][3];
    logic          dz_reg   [QW+1];

    logic [DW-1:0]    den_mag;
    logic [MAG_W-1:0] num_s   [3];
    logic [MAG_W-1:0] num_mag [3];

    always_comb begin
        den_mag = sum_reg[3][SW-1] ? DW'(-sum_reg[3]) : DW'(sum_reg[3]);
        for (int l = 0; l < 3; l++) begin
            num_s[l]   = MAG_W'(sum_reg[l]) << FRAC_BITS;
            num_mag[l] = sum_reg[l][SW-1] ? -num_s[l] : num_s[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den_mag;
            dz_reg[0]  <= (sum_reg[3] == '0);
            for (int l = 0; l < 3; l++) begin
                rem_reg[0][l] <= {{(DW-MAG_W+QW){1'b0}}, num_mag[l][MAG_W-1:QW]};
                nlo_reg[0][l] <= num_mag[l][QW-1:0];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= sum_reg[l][SW-1] ^ sum_reg[3][SW-1];
                ovf_reg[0][l] <= (num_mag[l] >> QW) >= {{(MAG_W-DW){1'b0}}, den_mag};
            end
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0]   trial [3];
        logic [DW:0]   diff  [3];
        logic [DW-1:0] rem_n [3];
        logic          bit_n [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                trial[l] = {rem_reg[k][l], nlo_reg[k][l][QW-1-k]};
                diff[l]  = trial[l] - {1'b0, den_reg[k]};
                bit_n[l] = !diff[l][DW];
                rem_n[l] = bit_n[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k+1] <= den_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                for (int l = 0; l < 3; l++) begin
                    rem_reg[k+1][l] <= rem_n[l];
                    nlo_reg[k+1][l] <= nlo_reg[k][l];
                    quo_reg[k+1][l] <= {quo_reg[k][l][QW-2:0], bit_n[l]};
                    neg_reg[k+1][l] <= neg_reg[k][l];
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end
    end

    // ---------------- output register: sign, clamp ----------------
    logic [vtd_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [vtd_pkg::TUSER_W-1:0] m_tuser_reg;

    logic [CW-1:0] res  [3];
    logic          satl [3];
    logic [QW-1:0] qneg [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qneg[l] = -quo_reg[QW][l];
            if (neg_reg[QW][l]) begin
                satl[l] = ovf_reg[QW][l] || (quo_reg[QW][l] > vtd_pkg::Q_NEG_MAX);
                res[l]  = satl[l] ? vtd_pkg::OUT_NEG_SAT : qneg[l][CW-1:0];
            end else begin
                satl[l] = ovf_reg[QW][l] || (quo_reg[QW][l] > vtd_pkg::Q_POS_MAX);
                res[l]  = satl[l] ? vtd_pkg::OUT_POS_SAT : quo_reg[QW][l][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dz_reg[QW]) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end else begin
                m_tdata_reg <= {res[2], res[1], res[0]};
                m_tuser_reg <= {satl[0] || satl[1] || satl[2], 1'b0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("divide-by-zero beat with nonzero data");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("div_zero and saturated both set");

    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> ($stable(dv_reg[QW]) && $stable(quo_reg[QW][0])))
        else $error("divider pipeline moved during stall");

endmodule
